[hw/rtl/svm_pkg.sv]
`default_nettype none
package svm_pkg;
  localparam int ThreadCountDef = 64;
  localparam int StackDepthDef  = 64;
  localparam int VarCount       = 256;

  localparam logic [15:0] PcNone    = 16'hFFFF;
  localparam logic [15:0] PcKill    = 16'hFFFE;
  localparam logic [7:0]  VarPartIx = 8'hE4;
  localparam logic [15:0] PartVal   = 16'h0014;
  localparam logic [7:0]  VarInitIx = 8'h54;
  localparam logic [15:0] InitVal   = 16'h0081;

  typedef enum logic [4:0] {
    ACT_MOVC = 5'd0, ACT_MOV = 5'd1, ACT_ADD = 5'd2, ACT_ADDC = 5'd3,
    ACT_SUB = 5'd4, ACT_AND = 5'd5, ACT_OR = 5'd6, ACT_SHL = 5'd7,
    ACT_SHR = 5'd8, ACT_CALL = 5'd9, ACT_RET = 5'd10, ACT_JMP = 5'd11,
    ACT_JNZ = 5'd12, ACT_CJMP = 5'd13, ACT_SETVEC = 5'd14, ACT_RESET = 5'd15,
    ACT_YIELD = 5'd16, ACT_KILL = 5'd17, ACT_START = 5'd18, ACT_END = 5'd19,
    ACT_COMMIT = 5'd20, ACT_PINIT = 5'd21
  } act_t;

  typedef enum logic [2:0] {
    ERR_OK = 3'd0, ERR_OVF = 3'd1, ERR_UNF = 3'd2, ERR_RANGE = 3'd3, ERR_COND = 3'd4
  } err_t;

  typedef enum logic [2:0] {
    CND_EQ = 3'd0, CND_NE = 3'd1, CND_GT = 3'd2, CND_GE = 3'd3, CND_LT = 3'd4,
    CND_LE = 3'd5
  } cnd_t;

  localparam logic [1:0] ModeKill = 2'd2;
  localparam logic [1:0] ModeNone = 2'd3;

  // request as it travels from front to back
  typedef struct packed {
    logic [4:0]  action;
    logic [7:0]  dest_index;
    logic [7:0]  source_index;
    logic [15:0] immediate;
    logic [2:0]  condition;
    logic        cmp_var;
    logic [15:0] target;
    logic [15:0] next_pc;
    logic [5:0]  thread_first;
    logic [5:0]  thread_last;
    logic [1:0]  reset_mode;
    logic        reads_var;  // needs the variable memory
    logic        walk;       // walks the thread table
  } req_t;

  typedef struct packed {
    logic [15:0] new_pc;
    logic        yield_thread;
    logic [2:0]  error_code;
    logic        thread_runnable;
    logic [15:0] written_value;
  } res_t;
endpackage
`default_nettype wire

[hw/rtl/script_vm_execute_unit.sv]
`default_nettype none
// Request path: variable ops read their operands (S_RD1, S_RD2) and then execute (S_EXEC, S_WALK);
// control ops execute directly; commit, part init and a range reset walk the thread table first.
// A new request is taken only after the previous result has been popped;
// a 2-entry queue lets input run ahead of execute.
// Reset: synchronous active-low; a clearing pass then clears the variable memory and
// thread tables, during which no request is taken into execution. Call stack is not cleared.
module script_vm_execute_unit import svm_pkg::*; #(
  parameter int THREAD_COUNT = ThreadCountDef,
  parameter int STACK_DEPTH  = StackDepthDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [4:0]  in_action,
  input  wire logic [7:0]  in_dest_index,
  input  wire logic [7:0]  in_source_index,
  input  wire logic signed [15:0] in_immediate,
  input  wire logic [2:0]  in_condition,
  input  wire logic        in_compare_with_variable,
  input  wire logic [15:0] in_target,
  input  wire logic [15:0] in_next_pc,
  input  wire logic [5:0]  in_thread_first,
  input  wire logic [5:0]  in_thread_last,
  input  wire logic [1:0]  in_reset_mode,
  output logic             empty,
  input  wire logic        pop,
  output logic [15:0]      out_new_pc,
  output logic             out_yield_thread,
  output logic [2:0]       out_error_code,
  output logic             out_thread_runnable,
  output logic signed [15:0] out_written_value
);
  logic q_valid, q_pop, res_valid;
  req_t q_req;
  res_t res;

  svm_front u_front (
    .clk, .rst_n, .push, .full,
    .action(in_action), .dest_index(in_dest_index), .source_index(in_source_index),
    .immediate(in_immediate), .condition(in_condition),
    .cmp_var(in_compare_with_variable), .target(in_target), .next_pc(in_next_pc),
    .thread_first(in_thread_first), .thread_last(in_thread_last),
    .reset_mode(in_reset_mode), .q_valid, .q_req, .q_pop
  );

  svm_back #(.THREAD_COUNT(THREAD_COUNT), .STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk, .rst_n, .q_valid, .q_req, .q_pop, .res_valid, .res, .res_pop(pop)
  );

  assign empty               = !res_valid;
  assign out_new_pc          = res.new_pc;
  assign out_yield_thread    = res.yield_thread;
  assign out_error_code      = res.error_code;
  assign out_thread_runnable = res.thread_runnable;
  assign out_written_value   = res.written_value;
endmodule
`default_nettype wire

[hw/rtl/svm_front.sv]
`default_nettype none
module svm_front import svm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [4:0]  action,
  input  wire logic [7:0]  dest_index,
  input  wire logic [7:0]  source_index,
  input  wire logic [15:0] immediate,
  input  wire logic [2:0]  condition,
  input  wire logic        cmp_var,
  input  wire logic [15:0] target,
  input  wire logic [15:0] next_pc,
  input  wire logic [5:0]  thread_first,
  input  wire logic [5:0]  thread_last,
  input  wire logic [1:0]  reset_mode,
  output logic             q_valid,
  output req_t             q_req,
  input  wire logic        q_pop
);
  // two-entry queue between classify and execute
  req_t       mem_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, rd_nxt, wr_r, wr_nxt;
  req_t       cls;
  logic       do_push;

  always_comb begin
    cls = '0;
    cls.action       = action;
    cls.dest_index   = dest_index;
    cls.source_index = source_index;
    cls.immediate    = immediate;
    cls.condition    = condition;
    cls.cmp_var      = cmp_var;
    cls.target       = target;
    cls.next_pc      = next_pc;
    cls.thread_first = thread_first;
    cls.thread_last  = thread_last;
    cls.reset_mode   = reset_mode;
    cls.reads_var    = (action <= ACT_SHR) || (action == ACT_JNZ) || (action == ACT_CJMP);
    cls.walk         = (action == ACT_COMMIT) || (action == ACT_PINIT) ||
                       ((action == ACT_RESET) && (thread_first <= thread_last) &&
                        (reset_mode != ModeNone));
  end

  assign full    = (cnt_r == 2'd2);
  assign do_push = push && !full;
  assign q_valid = (cnt_r != 2'd0);
  assign q_req   = mem_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, q_pop};
    rd_nxt  = rd_r ^ q_pop;
    wr_nxt  = wr_r ^ do_push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
    end
    if (do_push) mem_r[wr_r] <= cls;
  end
endmodule
`default_nettype wire

[hw/rtl/svm_back.sv]
`default_nettype none
module svm_back import svm_pkg::*; #(
  parameter int THREAD_COUNT = ThreadCountDef,
  parameter int STACK_DEPTH  = StackDepthDef
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  input  req_t      q_req,
  output logic      q_pop,
  output logic      res_valid,
  output res_t      res,
  input  wire logic res_pop
);
  localparam int TW = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
  localparam int SW = $clog2(STACK_DEPTH);
  localparam int LW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_RD1, S_RD2, S_EXEC, S_WALK, S_CLEAR, S_OUT
  } st_t;

  st_t         st_r;
  req_t        cur_r;
  res_t        res_r, exec_res;
  logic [15:0] var_mem [VarCount];
  logic [15:0] stk_mem [STACK_DEPTH];
  logic [LW-1:0] lvl_r;
  logic [15:0] tpc_mem [THREAD_COUNT];
  logic [15:0] rpc_mem [THREAD_COUNT];
  logic [THREAD_COUNT-1:0] tp_r, rp_r;
  logic [7:0]  rd_addr;
  logic [15:0] rd_data_r, vb_r, va_r, stk_q_r, tpc_q_r, rpc_q_r;
  logic [TW-1:0] wt_r, t_addr;
  logic [7:0]  clr_r;
  logic        clr_done_r;

  assign q_pop     = (st_r == S_IDLE) && q_valid && clr_done_r;
  assign res_valid = (st_r == S_OUT);
  assign res       = res_r;

  // compute result from operands
  logic [15:0] v;
  logic [15:0] alu;
  logic        wr;
  logic        take;
  logic [2:0]  err;
  logic [15:0] pc;
  logic signed [15:0] sb, sa;
  always_comb begin
    alu  = '0; wr = 1'b0; take = 1'b0; err = ERR_OK; pc = cur_r.next_pc;
    sb   = vb_r;
    sa   = cur_r.cmp_var ? va_r : cur_r.immediate;
    v    = vb_r;
    unique case (cur_r.action)
      ACT_MOVC: begin alu = cur_r.immediate; wr = 1'b1; end
      ACT_MOV:  begin alu = va_r; wr = 1'b1; end
      ACT_ADD:  begin alu = v + va_r; wr = 1'b1; end
      ACT_ADDC: begin alu = v + cur_r.immediate; wr = 1'b1; end
      ACT_SUB:  begin alu = v - va_r; wr = 1'b1; end
      ACT_AND:  begin alu = v & cur_r.immediate; wr = 1'b1; end
      ACT_OR:   begin alu = v | cur_r.immediate; wr = 1'b1; end
      ACT_SHL:  begin
        alu = (cur_r.immediate[15:4] != '0) ? '0 : (v << cur_r.immediate[3:0]);
        wr  = 1'b1;
      end
      ACT_SHR:  begin
        alu = (cur_r.immediate[15:4] != '0) ? '0 : (v >> cur_r.immediate[3:0]);
        wr  = 1'b1;
      end
      ACT_JNZ:  begin
        alu = v - 16'd1; wr = 1'b1;
        if (alu != '0) pc = cur_r.target;
      end
      ACT_CJMP: begin
        unique case (cur_r.condition)
          CND_EQ:  take = (sb == sa);
          CND_NE:  take = (sb != sa);
          CND_GT:  take = (sb > sa);
          CND_GE:  take = (sb >= sa);
          CND_LT:  take = (sb < sa);
          CND_LE:  take = (sb <= sa);
          default: err  = ERR_COND;
        endcase
        if (take) pc = cur_r.target;
      end
      default: ;
    endcase
  end

  assign rd_addr = (st_r == S_RD1) ? cur_r.dest_index : cur_r.source_index;

  logic tf_ok;
  assign tf_ok = ({2'b0, cur_r.thread_first} < 8'(THREAD_COUNT));
  logic [TW-1:0] tf_ix;
  assign tf_ix = cur_r.thread_first[TW-1:0];
  logic [TW-1:0] last_ix;
  assign last_ix = ({2'b0, cur_r.thread_last} < 8'(THREAD_COUNT)) ?
                   cur_r.thread_last[TW-1:0] : TW'(THREAD_COUNT - 1);
  logic q_tf_ok;
  assign q_tf_ok = ({2'b0, q_req.thread_first} < 8'(THREAD_COUNT));

  // thread table read address is set ahead of its use, as the read data is registered
  always_comb begin
    if (st_r == S_IDLE)
      t_addr = (q_req.action == ACT_COMMIT) ? '0 : q_req.thread_first[TW-1:0];
    else if (st_r == S_WALK)
      t_addr = wt_r + TW'(1);
    else
      t_addr = tf_ix;
  end

  // result of control ops
  always_comb begin
    exec_res = '{new_pc: cur_r.next_pc, yield_thread: 1'b0, error_code: ERR_OK,
                 thread_runnable: 1'b0, written_value: '0};
    unique case (cur_r.action)
      ACT_CALL: if (lvl_r >= LW'(STACK_DEPTH)) exec_res.error_code = ERR_OVF;
        else exec_res.new_pc = cur_r.target;
      ACT_RET: if (lvl_r == '0) exec_res.error_code = ERR_UNF;
        else exec_res.new_pc = stk_q_r;
      ACT_JMP: exec_res.new_pc = cur_r.target;
      ACT_RESET: if (cur_r.thread_first > cur_r.thread_last)
        exec_res.error_code = ERR_RANGE;
      ACT_YIELD: exec_res.yield_thread = 1'b1;
      ACT_KILL: begin exec_res.yield_thread = 1'b1; exec_res.new_pc = PcNone; end
      ACT_START: begin
        if (tf_ok) begin
          exec_res.new_pc = tpc_q_r;
          exec_res.thread_runnable = !tp_r[tf_ix] && (tpc_q_r != PcNone);
        end else exec_res.new_pc = PcNone;
      end
      ACT_PINIT: exec_res.written_value = PartVal;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_r == S_RD1 || st_r == S_RD2) rd_data_r <= var_mem[rd_addr];
    if (st_r == S_RD2) vb_r <= rd_data_r;
    if (st_r == S_EXEC) va_r <= rd_data_r;
    stk_q_r <= stk_mem[SW'(lvl_r - LW'(1))];
    tpc_q_r <= tpc_mem[t_addr];
    rpc_q_r <= rpc_mem[t_addr];
    if (st_r == S_CLEAR)
      var_mem[clr_r] <= (clr_r == VarInitIx) ? InitVal : '0;
    else if (st_r == S_OUT && cur_r.reads_var && wr)
      var_mem[cur_r.dest_index] <= alu;
    else if (st_r == S_WALK && cur_r.action == ACT_PINIT && wt_r == '0)
      var_mem[VarPartIx] <= PartVal;
    if (st_r == S_EXEC && cur_r.action == ACT_CALL && lvl_r < LW'(STACK_DEPTH))
      stk_mem[SW'(lvl_r)] <= cur_r.next_pc;
    if (st_r == S_CLEAR && clr_r < 8'(THREAD_COUNT)) begin
      tpc_mem[clr_r[TW-1:0]] <= PcNone;
      rpc_mem[clr_r[TW-1:0]] <= PcNone;
    end else if (st_r == S_EXEC && tf_ok) begin
      if (cur_r.action == ACT_END) tpc_mem[tf_ix] <= cur_r.next_pc;
      if (cur_r.action == ACT_SETVEC) rpc_mem[tf_ix] <= cur_r.target;
    end else if (st_r == S_WALK && !cur_r.reads_var) begin
      unique case (cur_r.action)
        ACT_RESET: if (cur_r.reset_mode == ModeKill) rpc_mem[wt_r] <= PcKill;
        ACT_COMMIT: if (rpc_q_r != PcNone) begin
          tpc_mem[wt_r] <= (rpc_q_r == PcKill) ? PcNone : rpc_q_r;
          rpc_mem[wt_r] <= PcNone;
        end
        default: begin // part init
          tpc_mem[wt_r] <= (wt_r == '0) ? 16'h0000 : PcNone;
          rpc_mem[wt_r] <= PcNone;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR;
      clr_r <= '0;
      clr_done_r <= 1'b0;
      lvl_r <= '0;
      tp_r <= '0;
      rp_r <= '0;
      wt_r <= '0;
    end else begin
      unique case (st_r)
        S_CLEAR: begin
          clr_r <= clr_r + 8'd1;
          if (clr_r == 8'hFF) begin clr_done_r <= 1'b1; st_r <= S_IDLE; end
        end
        S_IDLE: if (q_pop) begin
          cur_r <= q_req;
          wt_r  <= (q_req.action == ACT_RESET) ? q_req.thread_first[TW-1:0] : '0;
          st_r  <= q_req.reads_var ? S_RD1 :
                   ((q_req.walk && (q_tf_ok || q_req.action != ACT_RESET)) ?
                    S_WALK : S_EXEC);
        end
        S_RD1: st_r <= S_RD2;
        S_RD2: st_r <= S_EXEC;
        S_EXEC: begin
          res_r <= exec_res;
          unique case (cur_r.action)
            ACT_CALL:  if (lvl_r < LW'(STACK_DEPTH)) lvl_r <= lvl_r + LW'(1);
            ACT_RET:   if (lvl_r != '0) lvl_r <= lvl_r - LW'(1);
            ACT_START: lvl_r <= '0;
            default: ;
          endcase
          // variable ops pass through S_WALK so va_r is loaded before the result is formed
          st_r <= cur_r.reads_var ? S_WALK : S_OUT;
        end
        S_WALK: begin
          if (cur_r.reads_var) begin
            res_r <= '{new_pc: pc, yield_thread: 1'b0, error_code: err,
                       thread_runnable: 1'b0, written_value: wr ? alu : '0};
            st_r <= S_OUT;
          end else begin
            unique case (cur_r.action)
              ACT_RESET: if (cur_r.reset_mode != ModeKill) rp_r[wt_r] <= cur_r.reset_mode[0];
              ACT_COMMIT: tp_r[wt_r] <= rp_r[wt_r];
              default: begin // part init
                tp_r[wt_r] <= 1'b0;
                rp_r[wt_r] <= 1'b0;
              end
            endcase
            wt_r <= wt_r + TW'(1);
            if ((cur_r.action == ACT_RESET) ? (wt_r == last_ix)
                : (wt_r == TW'(THREAD_COUNT - 1))) st_r <= S_EXEC;
          end
        end
        S_OUT: if (res_pop) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
